/* design/sda_pkg.sv */
`default_nettype none

package sda_pkg;

	// Item kinds carried on the input tuser.
	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_START = 2'd1,
		OP_TICK  = 2'd2
	} op_t;

	// Animation modes.
	typedef enum logic [1:0] {
		MODE_PLAIN   = 2'd0,
		MODE_SWIPE   = 2'd1,
		MODE_FLICKER = 2'd2,
		MODE_ROBIN   = 2'd3
	} mode_t;

	localparam int unsigned DIGIT_W   = 3;
	localparam int unsigned PATTERN_W = 8;
	localparam int unsigned PERIOD_W  = 16;
	localparam int unsigned TICK_W    = 17;
	localparam int unsigned SLOTS     = 8;

	localparam logic [TICK_W-1:0] TICK_MAX = '1;

	// Segment masks of the three swipe column steps.
	localparam logic [PATTERN_W-1:0] SWIPE_SRC_0 = 8'h30;
	localparam logic [PATTERN_W-1:0] SWIPE_OLD_0 = 8'h4f;
	localparam logic [PATTERN_W-1:0] SWIPE_SRC_1 = 8'h79;
	localparam logic [PATTERN_W-1:0] SWIPE_OLD_1 = 8'h06;
	localparam logic [PATTERN_W-1:0] SWIPE_SRC_2 = 8'h7f;

	localparam logic [1:0] SWIPE_COLUMNS = 2'd3;
	localparam logic [1:0] ROBIN_PASSES  = 2'd1;

	typedef logic [DIGIT_W-1:0]   digit_t;
	typedef logic [PATTERN_W-1:0] pattern_t;

	// New display byte of one digit during a sweep.
	function automatic pattern_t swipe_mix(input pattern_t src, input pattern_t old,
			input logic [1:0] column);
		pattern_t val;
		case (column)
			2'd0: val = (src & SWIPE_SRC_0) | (old & SWIPE_OLD_0);
			2'd1: val = (src & SWIPE_SRC_1) | (old & SWIPE_OLD_1);
			default: val = src & SWIPE_SRC_2;
		endcase
		return val;
	endfunction

endpackage

`default_nettype wire

/* design/segment_display_animator.sv */
`default_nettype none

// Seven-segment display animator.
// Input beats arrive on the s_ channel; tuser selects the kind: load writes one
// source digit pattern, start chooses mode, digit range and step period, and a
// tick advances the running animation. Load, start and idle ticks produce no
// output.
// A tick of a running animation produces one output beat per digit of the
// range, from the first digit to the last, on the m_ channel. tlast marks the
// final beat of the animation run (the beat of the last digit once the
// animation has stopped).
// Sequence: the tick is taken and the step counters are updated, which moves the
// block into its sweep state; then, digit by digit, the shared digit unit reads
// the source and display stores at the sweep digit, forms the new display byte,
// writes it back and registers it in the output register as the next beat.
// s_tready is low during that sweep.
// When the receiver stalls, the output register holds its beat and the sweep
// waits; a new input beat can be accepted while the final beat still waits.
// Reset clears both pattern stores, stops any animation and empties the
// output register.
module segment_display_animator #(
	parameter int NUM_DIGITS      = 8,
	parameter int FLICKER_TOGGLES = 7
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [2:0] digit_index, [10:3] pattern, [12:11] anim_mode, [15:13] start_digit,
	// [18:16] end_digit, [34:19] period_ticks, [39:35] zero
	input  wire logic [39:0] s_tdata,
	// [1:0] operation
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [2:0] out_digit, [10:3] out_pattern, [11] playing, [15:12] zero
	output logic [15:0]      m_tdata,
	output logic             m_tlast
);

	localparam int DW = sda_pkg::DIGIT_W;
	localparam int TW = sda_pkg::TICK_W;

	// Highest digit a range may reach and the count of loadable digits.
	localparam logic [DW-1:0] TOP_DIGIT    = DW'((NUM_DIGITS > 8) ? 7 : NUM_DIGITS - 1);
	localparam logic [4:0]    DIGIT_COUNT  = 5'(NUM_DIGITS);
	localparam logic [3:0]    FLICK_LIMIT  = 4'(FLICKER_TOGGLES);

	typedef enum logic {
		ST_IDLE,
		ST_SWEEP
	} state_t;

	state_t state_q;

	// Pattern stores.
	sda_pkg::pattern_t src_q  [sda_pkg::SLOTS];
	sda_pkg::pattern_t disp_q [sda_pkg::SLOTS];

	// Animation state.
	sda_pkg::mode_t mode_q;
	logic           active_q;
	sda_pkg::digit_t first_q, last_q, cursor_q;
	logic [sda_pkg::PERIOD_W-1:0] period_q;
	logic [TW-1:0]  tick_q;
	logic [1:0]     column_q;
	logic           lit_q;
	logic [3:0]     toggle_q;
	logic           right_q;
	logic [1:0]     pass_q;

	// What the sweep applies to each digit of the current tick.
	sda_pkg::digit_t sweep_d_q;
	logic            step_q;      // a step fired on this tick
	logic            aux_q;       // flicker: fill from source; round robin: light a digit
	sda_pkg::digit_t step_dig_q;
	logic [1:0]      step_col_q;

	// Output register.
	logic            out_valid_q;
	sda_pkg::digit_t out_digit_q;
	sda_pkg::pattern_t out_pattern_q;
	logic            out_playing_q;
	logic            out_last_q;

	// Input fields.
	sda_pkg::op_t    in_op;
	sda_pkg::digit_t in_index, in_start, in_end;
	sda_pkg::pattern_t in_pattern;
	sda_pkg::mode_t  in_mode;
	logic [sda_pkg::PERIOD_W-1:0] in_period;

	assign in_op      = sda_pkg::op_t'(s_tuser);
	assign in_index   = s_tdata[2:0];
	assign in_pattern = s_tdata[10:3];
	assign in_mode    = sda_pkg::mode_t'(s_tdata[12:11]);
	assign in_start   = s_tdata[15:13];
	assign in_end     = s_tdata[18:16];
	assign in_period  = s_tdata[34:19];

	assign s_tready = (state_q == ST_IDLE);
	logic accept;
	assign accept = s_tvalid && s_tready;

	// Range clamping of a start beat.
	sda_pkg::digit_t clamp_start, clamp_end, range_end;
	assign clamp_start = (in_start > TOP_DIGIT) ? TOP_DIGIT : in_start;
	assign clamp_end   = (in_end > TOP_DIGIT) ? TOP_DIGIT : in_end;
	assign range_end   = (clamp_end < clamp_start) ? clamp_start : clamp_end;

	// Saturating tick count and step fire test.
	logic [TW-1:0] tick_inc;
	logic          fire;
	assign tick_inc = (tick_q == sda_pkg::TICK_MAX) ? tick_q : tick_q + TW'(1);
	assign fire     = tick_inc > {1'b0, period_q};

	logic [1:0] col_next;
	logic [3:0] toggle_next;
	assign col_next    = column_q + 2'd1;
	assign toggle_next = toggle_q + 4'd1;

	// Shared digit unit: one digit of the range per sweep cycle while the output is not stalled.
	sda_pkg::pattern_t unit_src, unit_old, unit_val;
	logic              unit_hit;
	assign unit_src = src_q[sweep_d_q];
	assign unit_old = disp_q[sweep_d_q];
	assign unit_hit = (sweep_d_q == step_dig_q);

	always_comb begin
		case (mode_q)
			sda_pkg::MODE_PLAIN: begin
				unit_val = unit_src;
			end
			sda_pkg::MODE_SWIPE: begin
				unit_val = (step_q && unit_hit) ?
					sda_pkg::swipe_mix(unit_src, unit_old, step_col_q) : unit_old;
			end
			sda_pkg::MODE_FLICKER: begin
				unit_val = aux_q ? unit_src : '0;
			end
			default: begin
				if (step_q) begin
					unit_val = (aux_q && unit_hit) ? unit_src : '0;
				end else begin
					unit_val = unit_old;
				end
			end
		endcase
	end

	logic advance;
	assign advance = (state_q == ST_SWEEP) && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			for (int i = 0; i < sda_pkg::SLOTS; i++) begin
				src_q[i]  <= '0;
				disp_q[i] <= '0;
			end
			mode_q        <= sda_pkg::MODE_PLAIN;
			active_q      <= 1'b0;
			first_q       <= '0;
			last_q        <= '0;
			cursor_q      <= '0;
			period_q      <= '0;
			tick_q        <= '0;
			column_q      <= '0;
			lit_q         <= 1'b1;
			toggle_q      <= '0;
			right_q       <= 1'b1;
			pass_q        <= '0;
			sweep_d_q     <= '0;
			step_q        <= 1'b0;
			aux_q         <= 1'b0;
			step_dig_q    <= '0;
			step_col_q    <= '0;
			out_valid_q   <= 1'b0;
			out_digit_q   <= '0;
			out_pattern_q <= '0;
			out_playing_q <= 1'b0;
			out_last_q    <= 1'b0;
		end else begin
			// During a sweep the beat slot is refilled by the sweep itself.
			if (out_valid_q && m_tready && (state_q != ST_SWEEP)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (in_op)
							sda_pkg::OP_LOAD: begin
								if ({2'b00, in_index} < DIGIT_COUNT) begin
									src_q[in_index] <= in_pattern;
								end
							end
							sda_pkg::OP_START: begin
								mode_q   <= in_mode;
								first_q  <= clamp_start;
								last_q   <= range_end;
								period_q <= in_period;
								tick_q   <= (in_mode == sda_pkg::MODE_ROBIN) ?
									{1'b0, in_period} : '0;
								cursor_q <= clamp_start;
								column_q <= '0;
								lit_q    <= 1'b1;
								toggle_q <= '0;
								right_q  <= 1'b1;
								pass_q   <= '0;
								active_q <= 1'b1;
							end
							sda_pkg::OP_TICK: begin
								if (active_q) begin
									state_q    <= ST_SWEEP;
									sweep_d_q  <= first_q;
									step_q     <= fire;
									aux_q      <= (mode_q == sda_pkg::MODE_ROBIN) ?
										(pass_q <= sda_pkg::ROBIN_PASSES) : lit_q;
									step_dig_q <= cursor_q;
									step_col_q <= column_q;
									case (mode_q)
										sda_pkg::MODE_PLAIN: begin
											active_q <= 1'b0;
										end
										sda_pkg::MODE_SWIPE: begin
											tick_q <= fire ? '0 : tick_inc;
											if (fire) begin
												if (col_next >= sda_pkg::SWIPE_COLUMNS) begin
													column_q <= '0;
													if (cursor_q >= last_q) begin
														active_q <= 1'b0;
													end else begin
														cursor_q <= cursor_q + DW'(1);
													end
												end else begin
													column_q <= col_next;
												end
											end
										end
										sda_pkg::MODE_FLICKER: begin
											tick_q <= fire ? '0 : tick_inc;
											if (fire) begin
												lit_q    <= !lit_q;
												toggle_q <= toggle_next;
												if (toggle_next == FLICK_LIMIT) begin
													active_q <= 1'b0;
												end
											end
										end
										default: begin
											// The count restarts only on a step that lights a digit.
											tick_q <= (fire && (pass_q <= sda_pkg::ROBIN_PASSES)) ?
												'0 : tick_inc;
											if (fire) begin
												if (pass_q > sda_pkg::ROBIN_PASSES) begin
													active_q <= 1'b0;
												end else begin
													if (right_q) begin
														if (cursor_q >= last_q) begin
															right_q <= 1'b0;
														end else begin
															cursor_q <= cursor_q + DW'(1);
														end
													end else if (cursor_q <= first_q) begin
														// Bounce back at the start digit.
														cursor_q <= first_q;
														pass_q   <= pass_q + 2'd1;
														right_q  <= 1'b1;
													end else begin
														cursor_q <= cursor_q - DW'(1);
													end
												end
											end
										end
									endcase
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SWEEP: begin
					if (advance) begin
						disp_q[sweep_d_q] <= unit_val;
						out_valid_q   <= 1'b1;
						out_digit_q   <= sweep_d_q;
						out_pattern_q <= unit_val;
						out_playing_q <= active_q;
						out_last_q    <= (sweep_d_q == last_q) && !active_q;
						if (sweep_d_q == last_q) begin
							state_q <= ST_IDLE;
						end else begin
							sweep_d_q <= sweep_d_q + DW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_playing_q, out_pattern_q, out_digit_q};
	assign m_tlast  = out_last_q;

	// The range never inverts.
	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		first_q <= last_q)
		else $error("digit range inverted");

	// The sweep stays inside the range.
	a_sweep_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SWEEP |-> (sweep_d_q >= first_q) && (sweep_d_q <= last_q))
		else $error("sweep digit outside range");

	// A tick of a running animation always starts a sweep.
	a_tick_sweeps: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (in_op == sda_pkg::OP_TICK) && active_q |=> state_q == ST_SWEEP)
		else $error("running tick did not sweep");

	// The final beat of a run never reports a running animation.
	a_last_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_last_q |-> !out_playing_q)
		else $error("last beat while playing");

	// A running flicker has not yet reached its toggle limit.
	a_flicker_limit: assert property (@(posedge clk) disable iff (!arst_n)
		active_q && (mode_q == sda_pkg::MODE_FLICKER) |-> toggle_q != FLICK_LIMIT)
		else $error("flicker ran past its toggle limit");

endmodule

`default_nettype wire
